/* rtl/aes_ctr_pkg.sv */
// Shared types, codes and tables of the AES-256 counter-mode cipher.
package aes_ctr_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int KEY_WORDS  = 8;
    localparam int RK_WORDS   = 4 * (NUM_ROUNDS + 1);
    localparam int RK_AW      = $clog2(RK_WORDS);
    localparam int RND_W      = $clog2(NUM_ROUNDS + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0    = 3'd0;
    localparam logic [2:0] CFG_KEY1    = 3'd1;
    localparam logic [2:0] CFG_KEY2    = 3'd2;
    localparam logic [2:0] CFG_KEY3    = 3'd3;
    localparam logic [2:0] CFG_IV_HIGH = 3'd4;
    localparam logic [2:0] CFG_IV_LOW  = 3'd5;
    localparam logic [2:0] CFG_MODE    = 3'd6;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        restart;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_count;
    } t_out_word;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // one round without key: sub bytes, shift rows, optional mix columns
    function automatic logic [127:0] round_body(input logic [127:0] s, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = sbox(b[4*((c+r)%4)+r]);
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (mix) begin
                o[127-32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                o[119-32*c -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                o[111-32*c -: 8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                o[103-32*c -: 8]  = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end else begin
                o[127-32*c -: 32] = {a0, a1, a2, a3};
            end
        end
        return o;
    endfunction

endpackage

/* rtl/aes256_ctr_cipher_top.sv */
// Top level of the AES-256 counter-mode cipher with round-key memory.
//
//   channel | valid    | stall    | payload
//   in      | i_valid  | o_stall  | i_word  (aes_ctr_pkg::t_in_word)
//   out     | o_valid  | i_stall  | o_word  (aes_ctr_pkg::t_out_word)
//   cfg     | i_cfg_we | -        | i_cfg_index, i_cfg_data
//
// A word is accepted in the idle state, waits in the read state for round-key
// row 0, then runs the round state through fourteen rounds and the final key
// addition, paced by the single read port of the 15-row round-key memory
// (one row per round). A key write starts an expansion of key words 8 to 59
// (one key word per cycle) after a reload of the key window; input is held off
// meanwhile. After reset the zero key is expanded likewise.
// The result sits in an output register; a new word is taken while it waits.
module aes256_ctr_cipher_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  aes_ctr_pkg::t_in_word i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output aes_ctr_pkg::t_out_word o_word,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data
);

    localparam int ROWS   = aes_ctr_pkg::NUM_ROUNDS + 1;
    localparam int ROW_AW = aes_ctr_pkg::RND_W;

    typedef enum logic [3:0] {
        ST_EXPAND = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_ROUND  = 4'b1000
    } t_state;

    // round-key memory, one 128-bit row per round
    logic [127:0] r_rk_mem [ROWS];
    logic [127:0] r_rk_rd;
    logic [ROW_AW-1:0] rd_addr;

    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_high, r_iv_low;
    logic         r_mode;
    logic [127:0] r_ctr;
    logic         r_rekey;

    t_state r_state;
    logic [5:0]  r_ex_idx;          // key word index being produced, 8..59
    logic [7:0]  r_rcon;
    logic [31:0] r_ex_win [8];      // last eight key words
    logic [95:0] r_ex_row;          // words of the current row so far

    logic [ROW_AW-1:0] r_round;
    logic [127:0] r_st;
    logic [127:0] r_data;
    logic [4:0]   r_count;
    logic         r_ctr_mode;

    logic         r_out_valid;

    // expansion step
    logic [31:0] ex_t, ex_w;
    always_comb begin
        ex_t = r_ex_win[7];
        if (r_ex_idx[2:0] == 3'd0)
            ex_t = aes_ctr_pkg::sub_word({ex_t[23:0], ex_t[31:24]}) ^ {r_rcon, 24'h0};
        else if (r_ex_idx[2:0] == 3'd4)
            ex_t = aes_ctr_pkg::sub_word(ex_t);
        ex_w = r_ex_win[0] ^ ex_t;
    end

    logic start, done_round, out_free;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE) || r_rekey;
    assign start    = i_valid && !o_stall;
    assign done_round = (r_state == ST_ROUND) &&
                        (r_round == ROW_AW'(aes_ctr_pkg::NUM_ROUNDS)) && out_free;

    // memory read address: row 0 before the first round, then the next round's row;
    // hold the last row while the result waits
    always_comb begin
        rd_addr = '0;
        if (r_state == ST_ROUND)
            rd_addr = (r_round == ROW_AW'(aes_ctr_pkg::NUM_ROUNDS)) ?
                      r_round : r_round + ROW_AW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_rk_rd <= r_rk_mem[rd_addr];
        if (r_state == ST_EXPAND) begin
            if (r_ex_idx[1:0] == 2'd3)
                r_rk_mem[r_ex_idx[5:2]] <= {r_ex_row, ex_w};
            else if (r_ex_idx == 6'd8)
                r_rk_mem[0] <= {r_ex_win[0], r_ex_win[1], r_ex_win[2], r_ex_win[3]};
            else if (r_ex_idx == 6'd9)
                r_rk_mem[1] <= {r_ex_win[3], r_ex_win[4], r_ex_win[5], r_ex_win[6]};
        end
    end

    // round datapath
    logic [127:0] st_keyed, st_next, ks_out, masked, ctr_in;
    logic [4:0]   sat;
    always_comb begin
        st_keyed = r_st ^ r_rk_rd;
        st_next  = aes_ctr_pkg::round_body(st_keyed,
                       r_round != ROW_AW'(aes_ctr_pkg::NUM_ROUNDS - 1));
        ks_out   = r_ctr_mode ? (st_keyed ^ r_data) : st_keyed;
        sat      = r_count[4] ? 5'd16 : r_count;
        for (int i = 0; i < 16; i++)
            masked[127-8*i -: 8] = (5'(i) < sat) ? ks_out[127-8*i -: 8] : 8'h00;
        ctr_in   = i_word.restart ? {r_iv_high, r_iv_low} : r_ctr;
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXPAND;
            r_ex_idx    <= 6'd8;
            r_rcon      <= 8'h01;
            r_rekey     <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_iv_high   <= '0;
            r_iv_low    <= '0;
            r_ctr       <= '0;
            r_round     <= '0;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            for (int i = 0; i < 8; i++) r_ex_win[i] <= '0;
        end else begin
            // load the output word or drop it once taken
            if (done_round)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_stall)
                r_out_valid <= 1'b0;
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    aes_ctr_pkg::CFG_KEY0, aes_ctr_pkg::CFG_KEY1,
                    aes_ctr_pkg::CFG_KEY2, aes_ctr_pkg::CFG_KEY3: begin
                        r_key[i_cfg_index[1:0]] <= i_cfg_data;
                        r_rekey <= 1'b1;
                    end
                    aes_ctr_pkg::CFG_IV_HIGH: r_iv_high <= i_cfg_data;
                    aes_ctr_pkg::CFG_IV_LOW:  r_iv_low  <= i_cfg_data;
                    aes_ctr_pkg::CFG_MODE:    r_mode    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_EXPAND: begin
                    // advance the key window by one word
                    for (int i = 0; i < 7; i++) r_ex_win[i] <= r_ex_win[i+1];
                    r_ex_win[7] <= ex_w;
                    r_ex_row <= {r_ex_row[63:0], ex_w};
                    if (r_ex_idx[2:0] == 3'd0) r_rcon <= aes_ctr_pkg::xtime(r_rcon);
                    if (r_ex_idx == 6'(aes_ctr_pkg::RK_WORDS - 1))
                        r_state <= ST_IDLE;
                    else
                        r_ex_idx <= r_ex_idx + 6'd1;
                end
                ST_IDLE: begin
                    if (r_rekey && !i_cfg_we) begin
                        // reload the window with the new key
                        for (int i = 0; i < 4; i++) begin
                            r_ex_win[2*i]   <= r_key[i][63:32];
                            r_ex_win[2*i+1] <= r_key[i][31:0];
                        end
                        r_ex_idx <= 6'd8;
                        r_rcon   <= 8'h01;
                        r_rekey  <= 1'b0;
                        r_state  <= ST_EXPAND;
                    end else if (start) begin
                        r_data     <= {i_word.data_high, i_word.data_low};
                        r_count    <= i_word.byte_count;
                        r_ctr_mode <= !r_mode;
                        r_st       <= r_mode ? {i_word.data_high, i_word.data_low} : ctr_in;
                        r_ctr      <= r_mode ? ctr_in : ctr_in + 128'd1;
                        r_round    <= '0;
                        r_state    <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_ROUND;
                ST_ROUND: begin
                    if (r_round != ROW_AW'(aes_ctr_pkg::NUM_ROUNDS)) begin
                        r_st    <= st_next;
                        r_round <= r_round + ROW_AW'(1);
                    end else if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // load the masked result after the final key addition
    always_ff @(posedge i_clk) begin
        if (done_round) begin
            o_word.result_high  <= masked[127:64];
            o_word.result_low   <= masked[63:0];
            o_word.result_count <= r_count;
        end
    end

    assign o_valid = r_out_valid;

endmodule
